// ===== hw/rtl/sfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared codes for the symbol frame assembler: item modes, result status,
// buffer states and the symbol alphabet.
// ----------------------------------------------------------------------------
package sfa_pkg;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_READ   = 2'd2,
        MODE_FINISH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FS_IDLE      = 2'd0,
        FS_RECEIVING = 2'd1,
        FS_ENDED     = 2'd2,
        FS_FULL      = 2'd3
    } frame_state_t;

    localparam logic [1:0] STAT_ACCEPTED  = 2'd0;
    localparam logic [1:0] STAT_REJECTED  = 2'd1;
    localparam logic [1:0] STAT_DONE      = 2'd2;
    localparam logic [1:0] STAT_NO_BUFFER = 2'd3;

    localparam logic [7:0] SYM_ONE  = 8'h54;
    localparam logic [7:0] SYM_ZERO = 8'h46;
    localparam logic [7:0] SYM_SYNC = 8'h53;
    localparam logic [7:0] SYM_MARK = 8'h4D;

endpackage

// ===== hw/rtl/sfa_byte_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_byte_ram
// Frame byte store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sfa_byte_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sfa_meta_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_meta_ram
// Per-buffer descriptor store: one write port, two read ports with
// registered data. Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module sfa_meta_ram #(
    parameter int DEPTH = 4,
    parameter int AW    = 2,
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= vld_reg[raddr_a] ? mem_reg[raddr_a] : '0;
        end
        if (re_b)
        begin
            rdata_b_reg <= vld_reg[raddr_b] ? mem_reg[raddr_b] : '0;
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hw/rtl/symbol_frame_assembler_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_frame_assembler_ring
// Ring of frame buffers that packs decoded radio symbols into frames.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries mode, symbol and byte_index.
// Mode start opens the next buffer of the ring, add stores one symbol in the
// buffer at the write pointer, read returns a byte of the buffer at the read
// pointer and finish releases that buffer. Every item gives exactly one
// result on the output channel (out_valid/out_ready): a status for the item
// plus a byte and the descriptor of the read-pointer buffer.
// From transfer to result register an item goes through these steps: a descriptor
// read, a byte read for the bit insert, the write-back together with the
// result byte read, then the result load. The byte read-modify-write through
// the single-port-write byte memory sets these steps; a new item is taken
// only after the result of the last one has been loaded.
// Reset clears the pointers, the frame counter and the descriptor valid
// bits, so all buffers read as idle at once; no memory clearing pass runs.
// When the receiver stalls, the result stays in the output register and one
// further item completes into it only after it is taken.
// ----------------------------------------------------------------------------
module symbol_frame_assembler_ring #(
    parameter int BUFFERS      = 4,
    parameter int FRAME_BYTES  = 64,
    parameter int SYMBOL_LIMIT = 320
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  symbol,
    input  logic [5:0]  byte_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  read_byte,
    output logic [9:0]  bit_count,
    output logic        has_error,
    output logic [9:0]  first_error_bit,
    output logic [1:0]  frame_state,
    output logic [15:0] frames_received
);

    localparam int PTR_W   = $clog2(BUFFERS);
    localparam int BIT_MAX = FRAME_BYTES * 8;
    localparam int BC_W    = $clog2(BIT_MAX + 1);
    localparam int SC_W    = $clog2(SYMBOL_LIMIT + 2);
    localparam int AW      = $clog2(BUFFERS * FRAME_BYTES);
    localparam int CMPW    = (BC_W - 3 > 6) ? BC_W - 3 : 6;

    typedef struct packed {
        sfa_pkg::frame_state_t st;
        logic                  ev;
        logic [BC_W-1:0]       ep;
        logic [SC_W-1:0]       sc;
        logic [BC_W-1:0]       bc;
    } meta_t;

    localparam int META_W = $bits(meta_t);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_UPDATE = 4'b0100,
        S_RESULT = 4'b1000
    } fsm_t;

    fsm_t                  state_reg, state_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [PTR_W-1:0]      rp_reg, rp_next;
    logic [15:0]           frames_reg;
    sfa_pkg::mode_t        mode_reg;
    logic [7:0]            sym_reg;
    logic [5:0]            idx_reg;
    logic [PTR_W-1:0]      tgt_reg, tgt_next;
    meta_t                 meta_new_reg;
    logic                  meta_we_reg;
    logic [1:0]            status_reg;
    logic                  bwe_reg;
    logic                  bit_one_reg;
    logic [2:0]            bpos_reg;
    logic [AW-1:0]         baddr_reg;
    logic                  fwd_hit_reg;
    logic [7:0]            fwd_byte_reg;

    logic                  out_valid_reg;
    logic [1:0]            status_out_reg;
    logic [7:0]            byte_out_reg;
    logic [9:0]            bc_out_reg;
    logic                  err_out_reg;
    logic [9:0]            ep_out_reg;
    logic [1:0]            fs_out_reg;
    logic [15:0]           frames_out_reg;

    logic                  acc;
    sfa_pkg::mode_t        mode_in;
    logic [PTR_W-1:0]      wp_inc, rp_inc;
    logic [META_W-1:0]     rdata_a, rdata_b;
    logic [7:0]            byte_rdata;
    meta_t                 meta_a;
    meta_t                 meta_upd;
    logic                  upd_we, upd_bwe, upd_inc;
    logic [1:0]            upd_status;
    logic [AW-1:0]         upd_baddr;
    logic                  bram_we, bram_re;
    logic [AW-1:0]         bram_raddr, oaddr;
    logic [7:0]            new_byte;
    logic                  load;
    meta_t                 meta_o;
    logic [7:0]            byte_src, byte_o;
    logic [CMPW-1:0]       hi_byte, ix_byte;

    assign acc      = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign mode_in  = sfa_pkg::mode_t'(mode);

    assign wp_inc = (wp_reg == PTR_W'(BUFFERS - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_W'(BUFFERS - 1)) ? '0 : rp_reg + 1'b1;

    // pointer update and target buffer at transfer
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        tgt_next = wp_reg;
        if (acc)
        begin
            if (mode_in == sfa_pkg::MODE_START)
            begin
                wp_next  = wp_inc;
                tgt_next = wp_inc;
            end
            if (mode_in == sfa_pkg::MODE_FINISH)
            begin
                rp_next  = rp_inc;
                tgt_next = rp_reg;
            end
        end
    end

    sfa_meta_ram #(
        .DEPTH (BUFFERS),
        .AW    (PTR_W),
        .WIDTH (META_W)
    ) u_meta_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (state_reg == S_UPDATE && meta_we_reg),
        .waddr   (tgt_reg),
        .wdata   (META_W'(meta_new_reg)),
        .re_a    (acc),
        .raddr_a (tgt_next),
        .rdata_a (rdata_a),
        .re_b    (acc),
        .raddr_b (rp_next),
        .rdata_b (rdata_b)
    );

    assign meta_a = meta_t'(rdata_a);

    // descriptor update for the item
    always_comb
    begin
        meta_upd   = meta_a;
        upd_we     = 1'b0;
        upd_bwe    = 1'b0;
        upd_inc    = 1'b0;
        upd_status = sfa_pkg::STAT_ACCEPTED;
        upd_baddr  = AW'(tgt_reg) * AW'(FRAME_BYTES) + AW'(meta_a.bc >> 3);
        unique case (mode_reg)
            sfa_pkg::MODE_START:
            begin
                if (meta_a.st == sfa_pkg::FS_IDLE)
                begin
                    meta_upd    = '0;
                    meta_upd.st = sfa_pkg::FS_RECEIVING;
                    meta_upd.sc = SC_W'(1);
                    upd_we      = 1'b1;
                end
                else
                begin
                    upd_status = sfa_pkg::STAT_NO_BUFFER;
                end
            end
            sfa_pkg::MODE_ADD:
            begin
                if (meta_a.st != sfa_pkg::FS_RECEIVING)
                begin
                    upd_status = sfa_pkg::STAT_REJECTED;
                end
                else
                begin
                    upd_we      = 1'b1;
                    meta_upd.sc = meta_a.sc + 1'b1;
                    if (sym_reg == sfa_pkg::SYM_ONE || sym_reg == sfa_pkg::SYM_ZERO)
                    begin
                        if (meta_a.bc < BC_W'(BIT_MAX))
                        begin
                            upd_bwe     = 1'b1;
                            meta_upd.bc = meta_a.bc + 1'b1;
                        end
                    end
                    else if (sym_reg == sfa_pkg::SYM_SYNC)
                    begin
                        meta_upd.st = sfa_pkg::FS_ENDED;
                    end
                    else if (sym_reg != sfa_pkg::SYM_MARK && !meta_a.ev)
                    begin
                        meta_upd.ev = 1'b1;
                        meta_upd.ep = meta_a.bc;
                    end
                    if (meta_upd.sc > SC_W'(SYMBOL_LIMIT))
                    begin
                        meta_upd.st = sfa_pkg::FS_FULL;
                    end
                    if (meta_upd.bc >= BC_W'(BIT_MAX))
                    begin
                        meta_upd.st = sfa_pkg::FS_FULL;
                    end
                    if (meta_upd.st != sfa_pkg::FS_RECEIVING)
                    begin
                        upd_inc    = 1'b1;
                        upd_status = sfa_pkg::STAT_DONE;
                    end
                end
            end
            sfa_pkg::MODE_READ:
            begin
                upd_status = sfa_pkg::STAT_ACCEPTED;
            end
            sfa_pkg::MODE_FINISH:
            begin
                meta_upd = '0;
                upd_we   = 1'b1;
            end
            default:
            begin
                upd_status = sfa_pkg::STAT_ACCEPTED;
            end
        endcase
    end

    // bit insert: keep earlier bits of the byte, drop stale later ones
    assign new_byte = (byte_rdata & ~(8'hFF >> bpos_reg))
                    | (bit_one_reg ? (8'h80 >> bpos_reg) : 8'h00);

    assign oaddr      = AW'(rp_reg) * AW'(FRAME_BYTES) + AW'(idx_reg);
    assign bram_we    = (state_reg == S_UPDATE) && bwe_reg;
    assign bram_re    = ((state_reg == S_FETCH) && upd_bwe) || (state_reg == S_UPDATE);
    assign bram_raddr = (state_reg == S_FETCH) ? upd_baddr : oaddr;

    sfa_byte_ram #(
        .DEPTH (BUFFERS * FRAME_BYTES),
        .AW    (AW)
    ) u_byte_ram (
        .clk   (clk),
        .we    (bram_we),
        .waddr (baddr_reg),
        .wdata (new_byte),
        .re    (bram_re),
        .raddr (bram_raddr),
        .rdata (byte_rdata)
    );

    // result view of the read-pointer buffer, with write-back forwarding
    assign meta_o   = (meta_we_reg && tgt_reg == rp_reg) ? meta_new_reg : meta_t'(rdata_b);
    assign byte_src = fwd_hit_reg ? fwd_byte_reg : byte_rdata;
    assign hi_byte  = CMPW'(meta_o.bc >> 3);
    assign ix_byte  = CMPW'(idx_reg);

    always_comb
    begin
        byte_o = 8'h00;
        if (hi_byte > ix_byte)
        begin
            byte_o = byte_src;
        end
        else if (hi_byte == ix_byte && meta_o.bc[2:0] != 3'd0)
        begin
            byte_o = byte_src & ~(8'hFF >> meta_o.bc[2:0]);
        end
    end

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            frames_reg    <= '0;
            meta_we_reg   <= 1'b0;
            bwe_reg       <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            if (acc)
            begin
                meta_we_reg <= 1'b0;
                bwe_reg     <= 1'b0;
            end
            if (state_reg == S_FETCH)
            begin
                meta_we_reg <= upd_we;
                bwe_reg     <= upd_bwe;
                if (upd_inc)
                begin
                    frames_reg <= frames_reg + 16'd1;
                end
            end
            if (state_reg == S_UPDATE)
            begin
                fwd_hit_reg <= bwe_reg && (oaddr == baddr_reg);
            end
            if (state_reg == S_RESULT && load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mode_reg <= mode_in;
            sym_reg  <= symbol;
            idx_reg  <= byte_index;
            tgt_reg  <= tgt_next;
        end
        if (state_reg == S_FETCH)
        begin
            meta_new_reg <= meta_upd;
            status_reg   <= upd_status;
            bit_one_reg  <= (sym_reg == sfa_pkg::SYM_ONE);
            bpos_reg     <= meta_a.bc[2:0];
            baddr_reg    <= upd_baddr;
        end
        if (state_reg == S_UPDATE)
        begin
            fwd_byte_reg <= new_byte;
        end
        if (state_reg == S_RESULT && load)
        begin
            status_out_reg <= status_reg;
            byte_out_reg   <= byte_o;
            bc_out_reg     <= 10'(meta_o.bc);
            err_out_reg    <= meta_o.ev;
            ep_out_reg     <= meta_o.ev ? 10'(meta_o.ep) : 10'd0;
            fs_out_reg     <= meta_o.st;
            frames_out_reg <= frames_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_out_reg;
    assign read_byte       = byte_out_reg;
    assign bit_count       = bc_out_reg;
    assign has_error       = err_out_reg;
    assign first_error_bit = ep_out_reg;
    assign frame_state     = fs_out_reg;
    assign frames_received = frames_out_reg;

endmodule

// ===== hw/rtl/sfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_checker
// Port-level checks for the symbol frame assembler, bound to the top level.
// ----------------------------------------------------------------------------
module sfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [9:0]  bit_count,
    input logic        has_error,
    input logic [9:0]  first_error_bit,
    input logic [1:0]  frame_state,
    input logic [15:0] frames_received
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(frames_received))
        else $error("result changed while stalled");

    // one item in flight
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // an idle buffer reports an empty descriptor
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_state == sfa_pkg::FS_IDLE |->
            bit_count == 10'd0 && !has_error)
        else $error("idle buffer shows data or error");

    // error position only with the error flag
    a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_error |-> first_error_bit == 10'd0)
        else $error("error position without error flag");

endmodule

bind symbol_frame_assembler_ring sfa_checker u_sfa_checker (.*);

// ===== dv/tb_symbol_frame_assembler_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symbol_frame_assembler_ring
// Self-checking bench for the symbol frame assembler ring. Open, symbol, read
// and release transfers go in; a local mirror of the buffer ring predicts each
// result, which is compared field by field in transfer order. Runs under
// several sender idle and receiver stall mixes and one long output hold.
// ----------------------------------------------------------------------------
module tb_symbol_frame_assembler_ring;
    import sfa_pkg::*;

    localparam int BUFFERS      = 4;
    localparam int FRAME_BYTES  = 64;
    localparam int SYMBOL_LIMIT = 320;
    localparam int FRAME_BITS   = FRAME_BYTES * 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [1:0]   status;
        logic [7:0]   rbyte;
        logic [9:0]   bits;
        logic         err;
        logic [9:0]   err_bit;
        frame_state_t fstate;
        logic [15:0]  frames;
    } frame_report_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  mode       = MODE_READ;
    logic [7:0]  symbol     = 8'h00;
    logic [5:0]  byte_index = 6'd0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [9:0]  bit_count;
    logic        has_error;
    logic [9:0]  first_error_bit;
    logic [1:0]  frame_state;
    logic [15:0] frames_received;

    // mirror of the buffer ring
    logic [7:0]   byte_mirror [BUFFERS * FRAME_BYTES];
    logic [9:0]   bits_mirror [BUFFERS];
    logic [8:0]   syms_mirror [BUFFERS];
    logic         err_mirror [BUFFERS];
    logic [9:0]   err_pos_mirror [BUFFERS];
    frame_state_t state_mirror [BUFFERS];
    logic [1:0]   wr_ptr;
    logic [1:0]   rd_ptr;
    logic [15:0]  frame_count;

    frame_report_t pending_reports [$];
    frame_report_t oldest_report;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic out_hold       = 1'b0;
    int   items_sent     = 0;
    int   results_seen   = 0;
    int   fail_count     = 0;
    int   cycle_count    = 0;
    int   status_seen [4] = '{0, 0, 0, 0};
    event hold_start;

    symbol_frame_assembler_ring #(
        .BUFFERS      (BUFFERS),
        .FRAME_BYTES  (FRAME_BYTES),
        .SYMBOL_LIMIT (SYMBOL_LIMIT)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .symbol          (symbol),
        .byte_index      (byte_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .read_byte       (read_byte),
        .bit_count       (bit_count),
        .has_error       (has_error),
        .first_error_bit (first_error_bit),
        .frame_state     (frame_state),
        .frames_received (frames_received)
    );

    always #1 clk = ~clk;

    function automatic void release_buffer(int b);
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            byte_mirror[b * FRAME_BYTES + i] = 8'h00;
        end
        bits_mirror[b]    = '0;
        syms_mirror[b]    = '0;
        err_mirror[b]     = 1'b0;
        err_pos_mirror[b] = '0;
        state_mirror[b]   = FS_IDLE;
    endfunction

    function automatic void reset_mirror();
        for (int b = 0; b < BUFFERS; b++)
        begin
            release_buffer(b);
        end
        wr_ptr      = '0;
        rd_ptr      = '0;
        frame_count = '0;
    endfunction

    function automatic logic [1:0] store_symbol(int b, logic [7:0] sym);
        int n;
        n = bits_mirror[b];
        if (state_mirror[b] != FS_RECEIVING)
            return STAT_REJECTED;
        if (sym == SYM_ONE || sym == SYM_ZERO)
        begin
            if (n < FRAME_BITS)
            begin
                if (sym == SYM_ONE)
                    byte_mirror[b * FRAME_BYTES + n / 8] |= 8'h80 >> (n % 8);
                bits_mirror[b] = n + 1;
            end
        end
        else if (sym == SYM_SYNC)
            state_mirror[b] = FS_ENDED;
        else if (sym != SYM_MARK && !err_mirror[b])
        begin
            err_mirror[b]     = 1'b1;
            err_pos_mirror[b] = n;
        end
        syms_mirror[b] = syms_mirror[b] + 1'b1;
        if (syms_mirror[b] > SYMBOL_LIMIT)
            state_mirror[b] = FS_FULL;
        if (bits_mirror[b] >= FRAME_BITS)
            state_mirror[b] = FS_FULL;
        if (state_mirror[b] != FS_RECEIVING)
        begin
            frame_count = frame_count + 1'b1;
            return STAT_DONE;
        end
        return STAT_ACCEPTED;
    endfunction

    function automatic frame_report_t assemble_step(mode_t m, logic [7:0] sym,
                                                    logic [5:0] idx);
        frame_report_t rep;
        int r;
        int cnt;
        int valid_bits;
        rep = '0;
        rep.status = STAT_ACCEPTED;
        case (m)
            MODE_START:
            begin
                wr_ptr = (wr_ptr + 1) % BUFFERS;
                if (state_mirror[wr_ptr] == FS_IDLE)
                begin
                    release_buffer(wr_ptr);
                    state_mirror[wr_ptr] = FS_RECEIVING;
                    syms_mirror[wr_ptr]  = 9'd1;
                end
                else
                    rep.status = STAT_NO_BUFFER;
            end
            MODE_ADD:
                rep.status = store_symbol(wr_ptr, sym);
            MODE_FINISH:
            begin
                release_buffer(rd_ptr);
                rd_ptr = (rd_ptr + 1) % BUFFERS;
            end
            default:
                ;
        endcase
        r   = rd_ptr;
        cnt = bits_mirror[r];
        if (idx < FRAME_BYTES && cnt > idx * 8)
        begin
            valid_bits = cnt - idx * 8;
            rep.rbyte  = byte_mirror[r * FRAME_BYTES + idx];
            if (valid_bits < 8)
                rep.rbyte = rep.rbyte & (8'hFF << (8 - valid_bits));
        end
        rep.bits    = cnt;
        rep.err     = err_mirror[r];
        rep.err_bit = err_mirror[r] ? err_pos_mirror[r] : 10'd0;
        rep.fstate  = state_mirror[r];
        rep.frames  = frame_count;
        return rep;
    endfunction

    function automatic logic [7:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return SYM_ONE;
        if (roll < 85)
            return SYM_ZERO;
        if (roll < 92)
            return SYM_MARK;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [5:0] pick_index();
        int top;
        top = bits_mirror[rd_ptr] / 8;
        if (top > FRAME_BYTES - 1)
            top = FRAME_BYTES - 1;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, FRAME_BYTES - 1);
        return $urandom_range(0, top);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic send_item(mode_t m, logic [7:0] sym, logic [5:0] idx);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        symbol     <= sym;
        byte_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_reports.push_back(assemble_step(m, sym, idx));
        items_sent++;
    endtask

    task automatic send_frame(int n_syms, bit with_sync, bit with_finish);
        int reads;
        send_item(MODE_START, $urandom_range(0, 255), $urandom_range(0, 63));
        for (int i = 0; i < n_syms; i++)
        begin
            send_item(MODE_ADD, pick_symbol(), $urandom_range(0, 63));
        end
        if (with_sync)
            send_item(MODE_ADD, SYM_SYNC, $urandom_range(0, 63));
        reads = $urandom_range(1, 3);
        repeat (reads) send_item(MODE_READ, $urandom_range(0, 255), pick_index());
        if (with_finish)
            send_item(MODE_FINISH, $urandom_range(0, 255), $urandom_range(0, 63));
    endtask

    task automatic test_directed();
        send_item(MODE_READ, 8'h00, 6'd0);
        send_item(MODE_READ, 8'hFF, 6'd63);
        // release of a buffer that was never opened
        send_item(MODE_FINISH, SYM_ONE, 6'd0);
        // no frame open at the write pointer
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        send_item(MODE_START, 8'hFF, 6'd0);
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        send_item(MODE_ADD, SYM_ZERO, 6'd0);
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        send_item(MODE_ADD, SYM_MARK, 6'd0);
        send_item(MODE_ADD, 8'h00, 6'd0);
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        send_item(MODE_ADD, 8'hFF, 6'd0);
        send_item(MODE_ADD, SYM_ZERO, 6'd0);
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        send_item(MODE_ADD, SYM_ZERO, 6'd0);
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        send_item(MODE_READ, SYM_ONE, 6'd0);
        send_item(MODE_READ, SYM_ONE, 6'd1);
        send_item(MODE_ADD, SYM_SYNC, 6'd2);
        send_item(MODE_ADD, SYM_ONE, 6'd1);
        repeat (3) send_item(MODE_START, SYM_ZERO, 6'd0);
        // ring wrapped onto the ended frame
        send_item(MODE_START, SYM_ZERO, 6'd0);
        send_item(MODE_FINISH, 8'h00, 6'd63);
        send_item(MODE_READ, 8'h00, 6'd63);
    endtask

    task automatic test_symbol_limit();
        repeat (BUFFERS) send_item(MODE_FINISH, 8'h00, 6'd0);
        while (rd_ptr != (wr_ptr + 1) % BUFFERS)
            send_item(MODE_FINISH, 8'h00, 6'd0);
        send_item(MODE_START, SYM_SYNC, 6'd0);
        repeat (SYMBOL_LIMIT - 1)
            send_item(MODE_ADD, $urandom_range(0, 1) ? SYM_ONE : SYM_ZERO,
                      $urandom_range(0, 63));
        // sync on the symbol that crosses the limit still leaves it full
        send_item(MODE_ADD, SYM_SYNC, 6'd0);
        send_item(MODE_ADD, SYM_ONE, 6'd0);
        for (int i = 0; i < 44; i += 4)
        begin
            send_item(MODE_READ, 8'h00, i);
        end
        send_item(MODE_READ, 8'h00, 6'd39);
        send_item(MODE_FINISH, 8'h00, 6'd0);
    endtask

    task automatic test_random_traffic(int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 75)
                send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(24, 80)
                                                        : $urandom_range(0, 20),
                           $urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0);
            else
                send_item(mode_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                          $urandom_range(0, 63));
        end
    endtask

    task automatic test_backpressure();
        -> hold_start;
        send_frame(12, 1'b1, 1'b1);
        send_frame(12, 1'b1, 1'b1);
    endtask

    always
    begin
        @(hold_start);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            status_seen[status]++;
            if (pending_reports.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                fail_count++;
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                check_field("status", oldest_report.status, status);
                check_field("read_byte", oldest_report.rbyte, read_byte);
                check_field("bit_count", oldest_report.bits, bit_count);
                check_field("has_error", oldest_report.err, has_error);
                check_field("first_error_bit", oldest_report.err_bit, first_error_bit);
                check_field("frame_state", oldest_report.fstate, frame_state);
                check_field("frames_received", oldest_report.frames, frames_received);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        reset_mirror();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(0, 0);
        test_directed();
        set_idling(6, 6);
        test_symbol_limit();
        set_idling(0, 0);
        test_random_traffic(170);
        set_idling(75, 0);
        test_random_traffic(170);
        set_idling(0, 75);
        test_random_traffic(170);
        set_idling(6, 6);
        test_random_traffic(170);
        set_idling(0, 0);
        test_backpressure();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        $display("run covered %0d transfers and %0d results, %0d frames completed",
                 items_sent, results_seen, frame_count);
        $display("status mix: %0d accepted, %0d rejected, %0d completed, %0d no buffer",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
